// File: hw/rtl/drq_pkg.sv
`timescale 1ns / 1ps

package drq_pkg;

	// Fixed field widths
	localparam int LABEL_BITS    = 48;
	localparam int START_BITS    = 47;
	localparam int EPS_BITS      = 52;
	localparam int COUNT_BITS    = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 52;

	// A coordinate difference of 2^MAG_CLIP or more exceeds any radius
	localparam int MAG_CLIP = 26;
	localparam int SQ_BITS  = 2 * MAG_CLIP;
	localparam int SUM_BITS = SQ_BITS + 2;

	// Queue between distance pipeline and accumulator
	localparam int QUEUE_DEPTH = 8;
	localparam int CREDIT_BITS = $clog2(QUEUE_DEPTH + 1);

	// Configuration register map
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_EPS_SQUARED = 3'd0,
		CFG_QUERY_X     = 3'd1,
		CFG_QUERY_Y     = 3'd2,
		CFG_QUERY_Z     = 3'd3,
		CFG_START_LABEL = 3'd4
	} cfg_reg_t;

	// Per-item flags passed from the front to the back
	typedef struct packed {
		logic hit;
		logic last;
	} drq_flags_t;

	localparam int FLAG_BITS = $bits(drq_flags_t);

endpackage

// File: hw/rtl/drq_if.sv
`timescale 1ns / 1ps

interface drq_nbr_if #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 40
) ();
	logic                                   valid;
	logic                                   ready;
	logic [INDEX_BITS-1:0]                  neighbour_index;
	logic signed [COORD_BITS-1:0]           coord_x;
	logic signed [COORD_BITS-1:0]           coord_y;
	logic signed [COORD_BITS-1:0]           coord_z;
	logic signed [drq_pkg::LABEL_BITS-1:0]  neighbour_label;
	logic                                   last_item;

	modport source (
		output valid, neighbour_index, coord_x, coord_y, coord_z, neighbour_label, last_item,
		input  ready
	);
	modport sink (
		input  valid, neighbour_index, coord_x, coord_y, coord_z, neighbour_label, last_item,
		output ready
	);
endinterface

interface drq_res_if #(
	parameter int INDEX_BITS = 40
) ();
	logic                            valid;
	logic                            ready;
	logic                            in_area;
	logic [INDEX_BITS-1:0]           area_index;
	logic [drq_pkg::COUNT_BITS-1:0]  running_count;
	logic [drq_pkg::LABEL_BITS-1:0]  running_label;
	logic                            query_done;

	modport source (
		output valid, in_area, area_index, running_count, running_label, query_done,
		input  ready
	);
	modport sink (
		input  valid, in_area, area_index, running_count, running_label, query_done,
		output ready
	);
endinterface

// File: hw/rtl/drq_front.sv
`timescale 1ns / 1ps

module drq_front #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	drq_nbr_if.sink                             nbr,
	input  logic [drq_pkg::EPS_BITS-1:0]        eps_squared,
	input  logic signed [COORD_BITS-1:0]        query [3],
	input  logic                                pop,
	output logic                                push,
	output logic [drq_pkg::FLAG_BITS+INDEX_BITS+drq_pkg::LABEL_BITS-1:0] entry
);
	import drq_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int MW = (DW > MAG_CLIP) ? DW : MAG_CLIP + 1;

	logic [CREDIT_BITS-1:0]   used_q;
	logic                     take;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	logic [INDEX_BITS-1:0]    index_s1, index_s2, index_s3, index_s4;
	logic [LABEL_BITS-1:0]    label_s1, label_s2, label_s3, label_s4;
	logic                     last_s1, last_s2, last_s3, last_s4;

	logic signed [DW-1:0]     diff_s1 [3];
	logic [MW-1:0]            mag_s2 [3];
	logic [SQ_BITS-1:0]       sq_s3 [3];
	logic [2:0]               big_s3;
	logic                     hit_s4;

	logic signed [COORD_BITS-1:0] coord [3];
	logic [DW-1:0]            abs_d [3];
	logic [SUM_BITS-1:0]      sum;
	drq_flags_t               flags;

	assign coord[0] = nbr.coord_x;
	assign coord[1] = nbr.coord_y;
	assign coord[2] = nbr.coord_z;

	// Admit an item only while a queue slot is reserved for it
	assign nbr.ready = (used_q < CREDIT_BITS'(QUEUE_DEPTH));
	assign take      = nbr.valid && nbr.ready;

	// Track items accepted and not yet drained from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (take && !pop) begin
			used_q <= used_q + 1'b1;
		end else if (!take && pop) begin
			used_q <= used_q - 1'b1;
		end
	end

	// Advance the valid bits every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Carry index, label and last marker alongside
	always_ff @(posedge clk) begin
		index_s1 <= nbr.neighbour_index;
		label_s1 <= nbr.neighbour_label;
		last_s1  <= nbr.last_item;
		index_s2 <= index_s1;
		label_s2 <= label_s1;
		last_s2  <= last_s1;
		index_s3 <= index_s2;
		label_s3 <= label_s2;
		last_s3  <= last_s2;
		index_s4 <= index_s3;
		label_s4 <= label_s3;
		last_s4  <= last_s3;
	end

	// Take absolute differences per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_d[i] = diff_s1[i][DW-1] ? DW'(-diff_s1[i]) : DW'(diff_s1[i]);
		end
	end

	// Stage 1 difference, stage 2 magnitude, stage 3 square and clip flag
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			diff_s1[i] <= DW'($signed({query[i][COORD_BITS-1], query[i]})
				- $signed({coord[i][COORD_BITS-1], coord[i]}));
			mag_s2[i]  <= MW'(abs_d[i]);
			sq_s3[i]   <= mag_s2[i][MAG_CLIP-1:0] * mag_s2[i][MAG_CLIP-1:0];
			big_s3[i]  <= |mag_s2[i][MW-1:MAG_CLIP];
		end
	end

	// Stage 4: sum the squares and compare against the radius
	assign sum = SUM_BITS'(sq_s3[0]) + SUM_BITS'(sq_s3[1]) + SUM_BITS'(sq_s3[2]);

	always_ff @(posedge clk) begin
		hit_s4 <= !(|big_s3) && (sum <= SUM_BITS'(eps_squared));
	end

	assign flags.hit  = hit_s4;
	assign flags.last = last_s4;
	assign push       = valid_s4;
	assign entry      = {flags, index_s4, label_s4};

endmodule

// File: hw/rtl/drq_queue.sv
`timescale 1ns / 1ps

module drq_queue #(
	parameter int WIDTH = 90,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/drq_back.sv
`timescale 1ns / 1ps

module drq_back #(
	parameter int INDEX_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                not_empty,
	input  logic [drq_pkg::FLAG_BITS+INDEX_BITS+drq_pkg::LABEL_BITS-1:0] head,
	input  logic [drq_pkg::START_BITS-1:0]      start_label,
	output logic                                pop,
	drq_res_if.source                           res
);
	import drq_pkg::*;

	drq_flags_t               flags;
	logic [INDEX_BITS-1:0]    index;
	logic [LABEL_BITS-1:0]    label;

	logic [COUNT_BITS-1:0]    cnt_q;
	logic [LABEL_BITS-1:0]    lab_q;
	logic                     mid_q;
	logic                     valid_q;
	logic                     in_area_q;
	logic [INDEX_BITS-1:0]    index_q;
	logic [COUNT_BITS-1:0]    count_out_q;
	logic [LABEL_BITS-1:0]    label_out_q;
	logic                     done_q;

	logic [COUNT_BITS-1:0]    cnt_base, cnt_next;
	logic [LABEL_BITS-1:0]    lab_base, lab_next, mag;

	assign {flags, index, label} = head;

	// Drain the queue whenever the output register is free or being taken
	assign pop = not_empty && (!valid_q || res.ready);

	// Fold the item into the running totals
	always_comb begin
		cnt_base = mid_q ? cnt_q : '0;
		lab_base = mid_q ? lab_q : LABEL_BITS'(start_label);
		mag      = -label;
		cnt_next = (flags.hit && cnt_base != '1) ? cnt_base + 1'b1 : cnt_base;
		lab_next = (flags.hit && label[LABEL_BITS-1] && mag < lab_base) ? mag : lab_base;
	end

	// Hold query state, restart after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mid_q <= 1'b0;
		end else if (pop) begin
			cnt_q <= flags.last ? '0 : cnt_next;
			mid_q <= !flags.last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lab_q <= lab_next;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			in_area_q   <= flags.hit;
			index_q     <= index;
			count_out_q <= cnt_next;
			label_out_q <= lab_next;
			done_q      <= flags.last;
		end
	end

	assign res.valid         = valid_q;
	assign res.in_area       = in_area_q;
	assign res.area_index    = index_q;
	assign res.running_count = count_out_q;
	assign res.running_label = label_out_q;
	assign res.query_done    = done_q;

endmodule

// File: hw/rtl/dbscan_region_query_top.sv
`timescale 1ns / 1ps

// Region query over a stream of candidate neighbours of one query point.
// Channel nbr brings one neighbour per transfer (index, x/y/z, label,
// last marker); channel res returns one result per neighbour: in-radius
// flag, echoed index, running count and running label, and query_done on
// the last neighbour of a query, after which count and label restart.
// Program eps_squared, query_x/y/z and start_label through cfg_we,
// cfg_index and cfg_data while no neighbour is in flight.
// From an nbr transfer to res valid, when the output register is free, an
// item passes four distance stages (difference, magnitude, square, sum and
// compare), a queue write, then the accumulator. Throughput is one
// neighbour per cycle while nbr.ready is high, set by the pipelined
// distance unit and the accumulator. An eight-entry queue decouples the
// two; nbr.ready drops only when the queue's slots are all reserved, so a
// stall on res backs up into nbr after at most nine pending results
// (eight reserved slots plus the one held in the output register).
// Reset clears the pipeline, queue and totals and sets the registers to
// their defaults (start_label to 1, the rest to 0).

module dbscan_region_query_top #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	drq_nbr_if.sink                              nbr,
	drq_res_if.source                            res,
	input  logic                                 cfg_we,
	input  logic [drq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [drq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import drq_pkg::*;

	localparam int ENTRY_BITS = FLAG_BITS + INDEX_BITS + LABEL_BITS;

	logic [EPS_BITS-1:0]          eps_squared_q;
	logic signed [COORD_BITS-1:0] query_q [3];
	logic [START_BITS-1:0]        start_label_q;

	logic                         push;
	logic                         pop;
	logic                         not_empty;
	logic [ENTRY_BITS-1:0]        entry;
	logic [ENTRY_BITS-1:0]        head;

	// Decode register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_squared_q <= '0;
			query_q[0]    <= '0;
			query_q[1]    <= '0;
			query_q[2]    <= '0;
			start_label_q <= START_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_EPS_SQUARED: eps_squared_q <= cfg_data[EPS_BITS-1:0];
				CFG_QUERY_X:     query_q[0]    <= cfg_data[COORD_BITS-1:0];
				CFG_QUERY_Y:     query_q[1]    <= cfg_data[COORD_BITS-1:0];
				CFG_QUERY_Z:     query_q[2]    <= cfg_data[COORD_BITS-1:0];
				CFG_START_LABEL: start_label_q <= cfg_data[START_BITS-1:0];
				default: ;
			endcase
		end
	end

	drq_front #(
		.COORD_BITS (COORD_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.nbr         (nbr),
		.eps_squared (eps_squared_q),
		.query       (query_q),
		.pop         (pop),
		.push        (push),
		.entry       (entry)
	);

	drq_queue #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	drq_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.head        (head),
		.start_label (start_label_q),
		.pop         (pop),
		.res         (res)
	);

endmodule

// File: test/drq_area_checker.sv
`timescale 1ns / 1ps

module drq_area_checker #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	drq_nbr_if                                nbr,
	drq_res_if                                res,
	input  logic                              cfg_we,
	input  logic [drq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [drq_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output int                                errors,
	output int                                pending
);
	import drq_pkg::*;

	typedef struct {
		logic                  hit;
		logic [INDEX_BITS-1:0] index;
		logic [COUNT_BITS-1:0] count;
		logic [LABEL_BITS-1:0] label;
		logic                  done;
	} area_entry_t;

	area_entry_t expected_area [$];

	// Shadow registers
	logic [EPS_BITS-1:0]          radius_sq;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;
	logic [START_BITS-1:0]        seed_label;

	// Per-query totals
	logic [COUNT_BITS-1:0] hit_count;
	logic [LABEL_BITS-1:0] min_label;
	bit                    in_query;

	// Square of one axis difference; a difference past the clip exceeds any radius
	function automatic logic [SUM_BITS-1:0] axis_square(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		longint d;
		longint unsigned m;
		d = longint'(a) - longint'(b);
		m = $unsigned((d < 0) ? -d : d);
		if (m >= (64'd1 << MAG_CLIP))
			return SUM_BITS'(64'd1 << SQ_BITS);
		return SUM_BITS'(m * m);
	endfunction

	// Apply one neighbour to the totals and queue the result it must produce
	task automatic account_neighbour(
		input logic [INDEX_BITS-1:0]        idx,
		input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y,
		input logic signed [COORD_BITS-1:0] z,
		input logic [LABEL_BITS-1:0]        lab,
		input logic                         last
	);
		logic [SUM_BITS-1:0]   sq_dist;
		logic [LABEL_BITS:0]   mag;
		area_entry_t           e;
		if (!in_query) begin
			min_label = LABEL_BITS'(seed_label);
			hit_count = '0;
			in_query  = 1'b1;
		end
		sq_dist = axis_square(center_x, x) + axis_square(center_y, y)
			+ axis_square(center_z, z);
		e.hit = (sq_dist <= SUM_BITS'(radius_sq));
		if (e.hit) begin
			if (hit_count != '1)
				hit_count = hit_count + 1'b1;
			// Negative label: take its magnitude when smaller
			if (lab[LABEL_BITS-1]) begin
				mag = {1'b0, ~lab} + 1'b1;
				if (mag < {1'b0, min_label})
					min_label = mag[LABEL_BITS-1:0];
			end
		end
		e.index = idx;
		e.count = hit_count;
		e.label = min_label;
		e.done  = last;
		expected_area.push_back(e);
		if (last) begin
			hit_count = '0;
			in_query  = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		area_entry_t want;
		if (!arst_n) begin
			radius_sq  = '0;
			center_x   = '0;
			center_y   = '0;
			center_z   = '0;
			seed_label = START_BITS'(1);
			hit_count  = '0;
			min_label  = '0;
			in_query   = 1'b0;
			expected_area.delete();
			pending <= 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
				CFG_EPS_SQUARED: radius_sq  = cfg_data[EPS_BITS-1:0];
				CFG_QUERY_X:     center_x   = cfg_data[COORD_BITS-1:0];
				CFG_QUERY_Y:     center_y   = cfg_data[COORD_BITS-1:0];
				CFG_QUERY_Z:     center_z   = cfg_data[COORD_BITS-1:0];
				CFG_START_LABEL: seed_label = cfg_data[START_BITS-1:0];
				default: ;
				endcase
			end
			// Predict on each neighbour transfer
			if (nbr.valid && nbr.ready)
				account_neighbour(nbr.neighbour_index, nbr.coord_x, nbr.coord_y,
					nbr.coord_z, nbr.neighbour_label, nbr.last_item);
			// Compare each result transfer against the oldest prediction
			if (res.valid && res.ready) begin
				if (expected_area.size() == 0) begin
					$error("area_index: expected none, actual %0h", res.area_index);
					errors++;
				end else begin
					want = expected_area.pop_front();
					check_field("in_area", want.hit, res.in_area);
					check_field("area_index", want.index, res.area_index);
					check_field("running_count", want.count, res.running_count);
					check_field("running_label", want.label, res.running_label);
					check_field("query_done", want.done, res.query_done);
				end
			end
			pending <= expected_area.size();
		end
	end

endmodule

// File: test/dbscan_region_query_top_tb.sv
`timescale 1ns / 1ps

module dbscan_region_query_top_tb;
	import drq_pkg::*;

	localparam int COORD_BITS  = 24;
	localparam int INDEX_BITS  = 40;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 36;

	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [LABEL_BITS-1:0] LABEL_MIN = {1'b1, {(LABEL_BITS-1){1'b0}}};
	localparam logic signed [LABEL_BITS-1:0] LABEL_MAX = {1'b0, {(LABEL_BITS-1){1'b1}}};
	localparam logic [START_BITS-1:0]        START_MAX = '1;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       errors;
	int                       pending;
	bit                       no_idle;
	bit                       hold_req;

	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;

	drq_nbr_if #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) nbr_ch ();
	drq_res_if #(.INDEX_BITS(INDEX_BITS)) res_ch ();

	dbscan_region_query_top #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.nbr(nbr_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	drq_area_checker #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS)
	) area_check (
		.clk(clk),
		.arst_n(arst_n),
		.nbr(nbr_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// Hard stop for a hung run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [LABEL_BITS-1:0] pick_label();
		case ($urandom_range(0, 9))
		0, 1, 2: return LABEL_BITS'(-longint'($urandom_range(1, 20000)));
		3:       return LABEL_MIN;
		4:       return '0;
		5, 6:    return LABEL_BITS'({$urandom, $urandom});
		7:       return LABEL_BITS'(longint'($urandom_range(1, 20000)));
		default: return LABEL_BITS'({$urandom, $urandom}) | LABEL_MIN;
		endcase
	endfunction

	// Exact center, a point near it, or anywhere
	function automatic logic signed [COORD_BITS-1:0] pick_coord(
		input logic signed [COORD_BITS-1:0] center,
		input int                           reach,
		input int                           mode
	);
		int off;
		if (mode == 0)
			return center;
		if (mode <= 6) begin
			off = int'($urandom_range(0, 2 * reach)) - reach;
			return COORD_BITS'(int'(center) + off);
		end
		return COORD_BITS'($urandom);
	endfunction

	// Offer one neighbour and hold it until the transfer
	task automatic send_nbr(
		input logic [INDEX_BITS-1:0]        idx,
		input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y,
		input logic signed [COORD_BITS-1:0] z,
		input logic signed [LABEL_BITS-1:0] lab,
		input bit                           last
	);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			nbr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		nbr_ch.valid           <= 1'b1;
		nbr_ch.neighbour_index <= idx;
		nbr_ch.coord_x         <= x;
		nbr_ch.coord_y         <= y;
		nbr_ch.coord_z         <= z;
		nbr_ch.neighbour_label <= lab;
		nbr_ch.last_item       <= last;
		do @(posedge clk); while (!nbr_ch.ready);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		nbr_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Write all five registers once the block is idle
	task automatic program_query(
		input logic [EPS_BITS-1:0]          eps,
		input logic signed [COORD_BITS-1:0] qx,
		input logic signed [COORD_BITS-1:0] qy,
		input logic signed [COORD_BITS-1:0] qz,
		input logic [START_BITS-1:0]        start
	);
		cfg_reg_t                 regs [5];
		logic [CFG_DATA_BITS-1:0] vals [5];
		drain_results();
		regs = '{CFG_EPS_SQUARED, CFG_QUERY_X, CFG_QUERY_Y, CFG_QUERY_Z, CFG_START_LABEL};
		vals = '{CFG_DATA_BITS'(eps),
			{{(CFG_DATA_BITS-COORD_BITS){1'b0}}, qx},
			{{(CFG_DATA_BITS-COORD_BITS){1'b0}}, qy},
			{{(CFG_DATA_BITS-COORD_BITS){1'b0}}, qz},
			CFG_DATA_BITS'(start)};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		center_x = qx;
		center_y = qy;
		center_z = qz;
	endtask

	// Result side: random stalls, a long hold on request, none in calm phases
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (no_idle) begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Neighbour side and verdict
	initial begin
		int                     reach;
		int                     left_in_query;
		int                     mode;
		int                     reach_opts [4];
		longint                 span;
		logic [EPS_BITS-1:0]    eps;
		logic [START_BITS-1:0]  start;
		logic signed [COORD_BITS-1:0] qx;
		logic signed [COORD_BITS-1:0] qy;
		logic signed [COORD_BITS-1:0] qz;

		reach_opts             = '{4, 100, 5000, 1 << 20};
		left_in_query          = 0;
		no_idle                = 1'b0;
		hold_req               = 1'b0;
		center_x               = '0;
		center_y               = '0;
		center_z               = '0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		nbr_ch.valid           = 1'b0;
		nbr_ch.neighbour_index = '0;
		nbr_ch.coord_x         = '0;
		nbr_ch.coord_y         = '0;
		nbr_ch.coord_z         = '0;
		nbr_ch.neighbour_label = '0;
		nbr_ch.last_item       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: zero radius around the origin, start label one
		send_nbr(0, 0, 0, 0, -1, 1'b0);
		send_nbr(1, 1, 0, 0, -1, 1'b1);

		// Inclusive boundary, miss with a lowering label, positive and most negative labels
		program_query(100, 0, 0, 0, 1000);
		send_nbr('1, 10, 0, 0, -7, 1'b0);
		send_nbr(2, 10, 1, 0, -3, 1'b0);
		send_nbr(3, -3, -4, -5, LABEL_MAX, 1'b0);
		send_nbr(4, 0, 0, -10, LABEL_MIN, 1'b0);
		send_nbr(5, 0, 0, 0, -1, 1'b1);

		// Widest radius, extreme coordinates, largest start label
		program_query('1, COORD_MIN, COORD_MAX, COORD_MIN, START_MAX);
		send_nbr(6, COORD_MAX, COORD_MIN, COORD_MAX, LABEL_MIN, 1'b0);
		send_nbr(7, COORD_MIN, COORD_MAX, COORD_MIN, LABEL_MIN + 1, 1'b0);
		send_nbr(8, 0, 0, 0, LABEL_MIN + 2, 1'b1);
		send_nbr(9, 0, 0, 0, 0, 1'b1);

		// Zero radius: exact match only, an all-miss query, then leave a query open
		program_query(0, 5, -5, 7, 1);
		send_nbr(10, 5, -5, 7, -1, 1'b0);
		send_nbr(11, 6, -5, 7, -1, 1'b1);
		send_nbr(12, 5, -5, 8, 5, 1'b1);
		send_nbr(13, 5, -5, 7, 0, 1'b0);

		// Random phases; queries may span a register update
		for (int ph = 0; ph < PHASES; ph++) begin
			reach = reach_opts[$urandom_range(0, 3)];
			span  = 3 * longint'(reach) * reach;
			case (ph)
			0: begin
				eps   = '1;
				qx    = COORD_MIN;
				qy    = COORD_MAX;
				qz    = COORD_MIN;
				start = START_MAX;
			end
			1: begin
				eps   = '0;
				qx    = COORD_MAX;
				qy    = COORD_MAX;
				qz    = COORD_MAX;
				start = 1;
			end
			default: begin
				case ($urandom_range(0, 3))
				0:       eps = EPS_BITS'({$urandom, $urandom});
				3:       eps = EPS_BITS'(longint'(reach) * reach);
				default: eps = EPS_BITS'(span * $urandom_range(0, 1000) / 1000);
				endcase
				qx = COORD_BITS'($urandom);
				qy = COORD_BITS'($urandom);
				qz = COORD_BITS'($urandom);
				case ($urandom_range(0, 3))
				0:       start = 1;
				1:       start = START_MAX;
				2:       start = $urandom_range(1, 20000);
				default: start = START_BITS'({$urandom, $urandom});
				endcase
				if (start == 0)
					start = 1;
			end
			endcase
			program_query(eps, qx, qy, qz, start);
			no_idle  = (ph % 4 == 3);
			hold_req = (ph == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (left_in_query == 0)
					left_in_query = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
				mode = $urandom_range(0, 9);
				send_nbr(INDEX_BITS'({$urandom, $urandom}),
					pick_coord(center_x, reach, mode),
					pick_coord(center_y, reach, mode),
					pick_coord(center_z, reach, mode),
					pick_label(), left_in_query == 1);
				left_in_query--;
			end
		end

		no_idle = 1'b0;
		drain_results();
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: dbscan_region_query_top.f
hw/rtl/drq_pkg.sv
hw/rtl/drq_if.sv
hw/rtl/drq_front.sv
hw/rtl/drq_queue.sv
hw/rtl/drq_back.sv
hw/rtl/dbscan_region_query_top.sv
test/drq_area_checker.sv
test/dbscan_region_query_top_tb.sv
